/* rtl/pptr_pkg.sv */
package pptr_pkg;

   localparam int AXES            = 3;
   localparam int ORDERS          = 3;
   localparam int COEF_W          = 32;
   localparam int TIME_W          = 24;
   localparam int ACC_W           = 40;
   localparam int SUM_W           = 50;
   localparam int MAX_SEGMENTS_DEF = 64;
   localparam int COEFFS_DEF      = 6;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_EVAL  = 1'b1;

   localparam logic signed [SUM_W-1:0] WIDE_HI = 50'sd549755813887;
   localparam logic signed [SUM_W-1:0] WIDE_LO = -50'sd549755813888;
   localparam logic signed [ACC_W-1:0] NARROW_HI = 40'sd2147483647;
   localparam logic signed [ACC_W-1:0] NARROW_LO = -40'sd2147483648;

   typedef struct packed {
      logic zero;
      logic ovf;
   } ctl_type;

   // derivative factor of coefficient j for result order o
   function automatic int deriv_factor(input int j, input int o);
      int f;
      f = 1;
      if (o >= 1) f = f * j;
      if (o >= 2) f = f * (j - 1);
      return f;
   endfunction

endpackage

/* rtl/pptr_ram.sv */
module pptr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [ADDR_W-1:0]        wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [ADDR_W-1:0]        rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

/* rtl/pptr_step.sv */
module pptr_step #(
   parameter int COEFFS = pptr_pkg::COEFFS_DEF,
   parameter int J      = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  pptr_pkg::ctl_type    in_ctl,
   input  logic [pptr_pkg::TIME_W-1:0] in_time,
   input  logic signed [pptr_pkg::COEF_W-1:0] in_coef [pptr_pkg::AXES][COEFFS],
   input  logic signed [pptr_pkg::ACC_W-1:0] in_acc [pptr_pkg::ORDERS][pptr_pkg::AXES],
   output logic                 out_valid,
   input  logic                 out_ready,
   output pptr_pkg::ctl_type    out_ctl,
   output logic [pptr_pkg::TIME_W-1:0] out_time,
   output logic signed [pptr_pkg::COEF_W-1:0] out_coef [pptr_pkg::AXES][COEFFS],
   output logic signed [pptr_pkg::ACC_W-1:0] out_acc [pptr_pkg::ORDERS][pptr_pkg::AXES]
);
   logic                 valid_ff;
   pptr_pkg::ctl_type    ctl_ff, ctl_in;
   logic [pptr_pkg::TIME_W-1:0] time_ff;
   logic signed [pptr_pkg::COEF_W-1:0] coef_ff [pptr_pkg::AXES][COEFFS];
   logic signed [pptr_pkg::ACC_W-1:0]  acc_ff [pptr_pkg::ORDERS][pptr_pkg::AXES];
   logic signed [pptr_pkg::ACC_W-1:0]  acc_in [pptr_pkg::ORDERS][pptr_pkg::AXES];
   logic [pptr_pkg::ORDERS-1:0][pptr_pkg::AXES-1:0] lane_ovf;

   // one horner step per lane with J >= o; the other lanes pass through
   for (genvar o = 0; o < pptr_pkg::ORDERS; o++) begin : g_ord
      for (genvar a = 0; a < pptr_pkg::AXES; a++) begin : g_ax
         if (J >= o) begin : g_step
            logic signed [39:0] dval;
            logic signed [64:0] prod;
            logic signed [64:0] rnd;
            logic signed [49:0] sum;
            assign dval = $signed({{8{in_coef[a][J][31]}}, in_coef[a][J]})
                        * $signed(40'(pptr_pkg::deriv_factor(J, o)));
            assign prod = $signed({{25{in_acc[o][a][39]}}, in_acc[o][a]})
                        * $signed({41'd0, in_time});
            assign rnd  = (prod + 65'sd32768) >>> 16;
            assign sum  = $signed(rnd[49:0]) + $signed({{10{dval[39]}}, dval});
            assign lane_ovf[o][a] = (sum > pptr_pkg::WIDE_HI) || (sum < pptr_pkg::WIDE_LO);
            assign acc_in[o][a] = (sum > pptr_pkg::WIDE_HI) ? pptr_pkg::WIDE_HI[39:0] :
                                  (sum < pptr_pkg::WIDE_LO) ? pptr_pkg::WIDE_LO[39:0] :
                                  sum[39:0];
         end else begin : g_pass
            assign lane_ovf[o][a] = 1'b0;
            assign acc_in[o][a]   = in_acc[o][a];
         end
      end
   end

   always_comb begin
      ctl_in      = in_ctl;
      ctl_in.ovf  = in_ctl.ovf | (|lane_ovf);
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         ctl_ff  <= ctl_in;
         time_ff <= in_time;
         coef_ff <= in_coef;
         acc_ff  <= acc_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_ctl   = ctl_ff;
   assign out_time  = time_ff;
   assign out_coef  = coef_ff;
   assign out_acc   = acc_ff;
endmodule

/* rtl/pptr_out.sv */
module pptr_out (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  pptr_pkg::ctl_type in_ctl,
   input  logic signed [pptr_pkg::ACC_W-1:0] in_acc [pptr_pkg::ORDERS][pptr_pkg::AXES],
   output logic              out_valid,
   input  logic              out_ready,
   output logic signed [31:0] out_res [pptr_pkg::ORDERS][pptr_pkg::AXES],
   output logic              out_ovf
);
   logic              valid_ff;
   logic              ovf_ff, ovf_in;
   logic signed [31:0] res_ff [pptr_pkg::ORDERS][pptr_pkg::AXES];
   logic signed [31:0] res_in [pptr_pkg::ORDERS][pptr_pkg::AXES];
   logic [pptr_pkg::ORDERS-1:0][pptr_pkg::AXES-1:0] sat;

   always_comb begin
      for (int o = 0; o < pptr_pkg::ORDERS; o++) begin
         for (int a = 0; a < pptr_pkg::AXES; a++) begin
            sat[o][a] = (in_acc[o][a] > pptr_pkg::NARROW_HI)
                     || (in_acc[o][a] < pptr_pkg::NARROW_LO);
            if (in_ctl.zero) begin
               res_in[o][a] = '0;
            end else if (in_acc[o][a] > pptr_pkg::NARROW_HI) begin
               res_in[o][a] = pptr_pkg::NARROW_HI[31:0];
            end else if (in_acc[o][a] < pptr_pkg::NARROW_LO) begin
               res_in[o][a] = pptr_pkg::NARROW_LO[31:0];
            end else begin
               res_in[o][a] = in_acc[o][a][31:0];
            end
         end
      end
      // out of range segment gives all zero fields
      ovf_in = !in_ctl.zero && (in_ctl.ovf || (|sat));
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         res_ff <= res_in;
         ovf_ff <= ovf_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_res   = res_ff;
   assign out_ovf   = ovf_ff;
endmodule

/* rtl/piecewise_poly_trajectory_eval.sv */
// Piecewise polynomial trajectory evaluator.
// Request channel (req_*): cmd 0 stores one Q16.16 coefficient at
// segment/axis/coef_index, cmd 1 evaluates a segment at local time
// eval_time (unsigned Q8.16). Writes produce no response; each evaluate
// produces exactly one response (rsp_*) with position, velocity and
// acceleration per axis in Q16.16, saturated, and an overflow flag.
// Responses come back in request order.
// Pipeline: the coefficient RAM read register is loaded at the request
// transfer, then one horner stage per coefficient and one output
// saturation stage follow.
// Throughput: one request per cycle while no stage stalls; the
// pipeline stages each hold one item and each advances when its
// successor has room. A coefficient written is visible to any
// evaluate transferred after it. Reset clears only the pipeline
// valid bits; coefficient RAM contents are undefined until written.
// When the receiver stalls, results stay in their stages and bubbles
// close up; req_ready drops only once every stage is full.
module piecewise_poly_trajectory_eval #(
   parameter int MAX_SEGMENTS    = pptr_pkg::MAX_SEGMENTS_DEF,
   parameter int COEFFS_PER_AXIS = pptr_pkg::COEFFS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [5:0]  req_segment,
   input  logic [1:0]  req_axis,
   input  logic [2:0]  req_coef_index,
   input  logic signed [31:0] req_coef_value,
   input  logic [23:0] req_eval_time,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic signed [31:0] rsp_pos_z,
   output logic signed [31:0] rsp_vel_x,
   output logic signed [31:0] rsp_vel_y,
   output logic signed [31:0] rsp_vel_z,
   output logic signed [31:0] rsp_acc_x,
   output logic signed [31:0] rsp_acc_y,
   output logic signed [31:0] rsp_acc_z,
   output logic        rsp_overflow
);
   localparam int C      = COEFFS_PER_AXIS;
   localparam int SEG_AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

   logic                        seg_bad;
   logic                        wr_xfer;
   logic [pptr_pkg::AXES*C-1:0] bank_we;

   logic                        vld_s  [C+1];
   logic                        rdy_s  [C+2];
   pptr_pkg::ctl_type           ctl_s  [C+1];
   logic [pptr_pkg::TIME_W-1:0] time_s [C+1];
   logic signed [31:0]          coef_s [C+1][pptr_pkg::AXES][C];
   logic signed [39:0]          acc_s  [C+1][pptr_pkg::ORDERS][pptr_pkg::AXES];

   logic                        vld0_ff;
   pptr_pkg::ctl_type           ctl0_ff;
   logic [pptr_pkg::TIME_W-1:0] time0_ff;
   logic signed [31:0]          res [pptr_pkg::ORDERS][pptr_pkg::AXES];

   assign seg_bad   = (11'(req_segment) >= 11'(MAX_SEGMENTS));
   assign req_ready = rdy_s[0];
   assign wr_xfer   = req_valid && req_ready && (req_cmd == pptr_pkg::CMD_WRITE);

   // one ram bank per axis and coefficient, addressed by segment
   for (genvar a = 0; a < pptr_pkg::AXES; a++) begin : g_bank_ax
      for (genvar j = 0; j < C; j++) begin : g_bank_c
         logic [31:0] rd;
         assign bank_we[a*C+j] = wr_xfer && !seg_bad && (req_axis == 2'(a))
                               && (4'(req_coef_index) == 4'(j));
         pptr_ram #(.WIDTH(32), .DEPTH(MAX_SEGMENTS)) u_ram (
            .clock   (clock),
            .wr_en   (bank_we[a*C+j]),
            .wr_addr (SEG_AW'(req_segment)),
            .wr_data (req_coef_value),
            .rd_en   (rdy_s[0]),
            .rd_addr (SEG_AW'(req_segment)),
            .rd_data (rd)
         );
         assign coef_s[0][a][j] = $signed(rd);
      end
   end

   // stage 0 runs alongside the ram read register
   assign rdy_s[0] = !vld0_ff || rdy_s[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff <= 1'b0;
      end else if (rdy_s[0]) begin
         vld0_ff <= req_valid && (req_cmd == pptr_pkg::CMD_EVAL);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_s[0]) begin
         ctl0_ff.zero <= seg_bad;
         ctl0_ff.ovf  <= 1'b0;
         time0_ff     <= req_eval_time;
      end
   end

   assign vld_s[0]  = vld0_ff;
   assign ctl_s[0]  = ctl0_ff;
   assign time_s[0] = time0_ff;

   for (genvar o = 0; o < pptr_pkg::ORDERS; o++) begin : g_zo
      for (genvar a = 0; a < pptr_pkg::AXES; a++) begin : g_za
         assign acc_s[0][o][a] = '0;
      end
   end

   // horner stages, highest power first
   for (genvar k = 1; k <= C; k++) begin : g_stage
      pptr_step #(.COEFFS(C), .J(C - k)) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (vld_s[k-1]),
         .in_ready  (rdy_s[k]),
         .in_ctl    (ctl_s[k-1]),
         .in_time   (time_s[k-1]),
         .in_coef   (coef_s[k-1]),
         .in_acc    (acc_s[k-1]),
         .out_valid (vld_s[k]),
         .out_ready (rdy_s[k+1]),
         .out_ctl   (ctl_s[k]),
         .out_time  (time_s[k]),
         .out_coef  (coef_s[k]),
         .out_acc   (acc_s[k])
      );
   end

   pptr_out u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld_s[C]),
      .in_ready  (rdy_s[C+1]),
      .in_ctl    (ctl_s[C]),
      .in_acc    (acc_s[C]),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_res   (res),
      .out_ovf   (rsp_overflow)
   );

   assign rsp_pos_x = res[0][0];
   assign rsp_pos_y = res[0][1];
   assign rsp_pos_z = res[0][2];
   assign rsp_vel_x = res[1][0];
   assign rsp_vel_y = res[1][1];
   assign rsp_vel_z = res[1][2];
   assign rsp_acc_x = res[2][0];
   assign rsp_acc_y = res[2][1];
   assign rsp_acc_z = res[2][2];

   a_one_bank_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0(bank_we))
      else $error("more than one coefficient bank written");

   a_write_on_transfer: assert property (@(posedge clock) disable iff (reset)
      (|bank_we) |-> (req_valid && req_ready && !seg_bad))
      else $error("coefficient write without a valid write transfer");

   a_stage0_holds: assert property (@(posedge clock) disable iff (reset)
      (vld0_ff && !rdy_s[1]) |=> (vld0_ff && $stable(time0_ff)))
      else $error("stalled item lost from ram read stage");

   a_no_accept_when_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready && vld0_ff && !rdy_s[1]) |-> !req_ready)
      else $error("request accepted while pipeline is full");
endmodule
